### sv/rtqc_pkg.sv
// Shared types, widths and sine table function for the rotated sprite corner generator.
package rtqc_pkg;

  localparam int POS_W   = 24;
  localparam int SIZE_W  = 23;
  localparam int ANGLE_W = 16;
  localparam int SLOT_W  = 5;
  localparam int CW      = SIZE_W + 2;

  localparam int SINE_TABLE_DEPTH_DEF   = 1024;
  localparam int SINE_FRACTION_BITS_DEF = 15;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

  typedef enum logic [1:0] {
    CORNER_LB,
    CORNER_RB,
    CORNER_RT,
    CORNER_LT
  } corner_t;

  typedef struct packed {
    logic              valid;
    corner_t           idx;
    logic              u;
    logic              v;
    logic              last;
    logic [SLOT_W-1:0] slot;
  } corner_ctl_t;

  function automatic longint unsigned sine_entry(input longint unsigned x, input int frac);
    longint unsigned term;
    longint signed   sum;
    longint unsigned s;
    term = x;
    sum  = longint'(x);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 6;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 20;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 42;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 72;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 110;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 156;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    s = longint'(sum);
    return (s + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage

### sv/rotated_textured_quad_corners.sv
// Top level of the rotated sprite corner generator.
// Path: an accepted item passes the input registers, the sine/cosine lookup,
// the corner sequencer and the corner math registers to the outputs; the other
// three corners follow on consecutive cycles. The corner sequencer emits one corner
// per cycle; busy is raised after each accept and start is ignored while busy is high.
// Reset: synchronous, active low; clears valid bits, the sequencer and the busy counter.
module rotated_textured_quad_corners #(
  parameter int SINE_TABLE_DEPTH   = rtqc_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SINE_FRACTION_BITS = rtqc_pkg::SINE_FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rtqc_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [rtqc_pkg::POS_W-1:0] in_pos_y,
  input  logic [rtqc_pkg::SIZE_W-1:0]       in_size_w,
  input  logic [rtqc_pkg::SIZE_W-1:0]       in_size_h,
  input  logic [rtqc_pkg::ANGLE_W-1:0]      in_angle,
  input  logic                              in_centered,
  input  logic [rtqc_pkg::SLOT_W-1:0]       in_tex_slot,
  output logic                              out_valid,
  output logic signed [rtqc_pkg::POS_W-1:0] out_vert_x,
  output logic signed [rtqc_pkg::POS_W-1:0] out_vert_y,
  output logic                              out_tex_u,
  output logic                              out_tex_v,
  output logic [rtqc_pkg::SLOT_W-1:0]       out_slot_out,
  output logic [1:0]                        out_corner_index,
  output logic                              out_last_corner
);
  import rtqc_pkg::*;

  localparam int SW = SINE_FRACTION_BITS + 2;

  logic       accept;
  logic [1:0] hold_r;

  assign accept = start && !busy;
  assign busy   = (hold_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 2'd0;
    end else if (accept) begin
      hold_r <= 2'd3;
    end else if (hold_r != 2'd0) begin
      hold_r <= hold_r - 2'd1;
    end
  end

  logic                    v1_r, v2_r, v3_r;
  logic signed [POS_W-1:0] px1_r, py1_r, px2_r, py2_r, px3_r, py3_r;
  logic [SIZE_W-1:0]       w1_r, h1_r, w2_r, h2_r;
  logic [ANGLE_W-1:0]      ang1_r;
  logic                    cen1_r, cen2_r;
  logic [SLOT_W-1:0]       slot1_r, slot2_r, slot3_r;
  logic signed [CW-1:0]    lx3_r, rx3_r, by3_r, ty3_r;
  logic signed [CW-1:0]    lx_nxt, rx_nxt, by_nxt, ty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    if (cen2_r) begin
      lx_nxt = -$signed({2'b00, w2_r});
      rx_nxt = $signed({2'b00, w2_r});
      by_nxt = -$signed({2'b00, h2_r});
      ty_nxt = $signed({2'b00, h2_r});
    end else begin
      lx_nxt = '0;
      rx_nxt = $signed({1'b0, w2_r, 1'b0});
      by_nxt = '0;
      ty_nxt = $signed({1'b0, h2_r, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    px1_r   <= in_pos_x;
    py1_r   <= in_pos_y;
    w1_r    <= in_size_w;
    h1_r    <= in_size_h;
    ang1_r  <= in_angle;
    cen1_r  <= in_centered;
    slot1_r <= in_tex_slot;
    px2_r   <= px1_r;
    py2_r   <= py1_r;
    w2_r    <= w1_r;
    h2_r    <= h1_r;
    cen2_r  <= cen1_r;
    slot2_r <= slot1_r;
    px3_r   <= px2_r;
    py3_r   <= py2_r;
    slot3_r <= slot2_r;
    lx3_r   <= lx_nxt;
    rx3_r   <= rx_nxt;
    by3_r   <= by_nxt;
    ty3_r   <= ty_nxt;
  end

  logic signed [SW-1:0] sin3, cos3;

  rtqc_sincos #(
    .SINE_TABLE_DEPTH  (SINE_TABLE_DEPTH),
    .SINE_FRACTION_BITS(SINE_FRACTION_BITS)
  ) u_sincos (
    .clk    (clk),
    .angle  (ang1_r),
    .sin_out(sin3),
    .cos_out(cos3)
  );

  corner_ctl_t             seq_ctl, out_ctl;
  logic signed [CW-1:0]    seq_cx, seq_cy;
  logic signed [SW-1:0]    seq_sin, seq_cos;
  logic signed [POS_W-1:0] seq_px, seq_py;

  rtqc_corner_seq #(
    .SINE_FRACTION_BITS(SINE_FRACTION_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (v3_r),
    .sin_in (sin3),
    .cos_in (cos3),
    .lx     (lx3_r),
    .rx     (rx3_r),
    .by     (by3_r),
    .ty     (ty3_r),
    .px     (px3_r),
    .py     (py3_r),
    .slot   (slot3_r),
    .ctl    (seq_ctl),
    .cx     (seq_cx),
    .cy     (seq_cy),
    .sin_out(seq_sin),
    .cos_out(seq_cos),
    .px_out (seq_px),
    .py_out (seq_py)
  );

  rtqc_corner_math #(
    .SINE_FRACTION_BITS(SINE_FRACTION_BITS)
  ) u_math (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (seq_ctl),
    .cx     (seq_cx),
    .cy     (seq_cy),
    .sin_in (seq_sin),
    .cos_in (seq_cos),
    .px     (seq_px),
    .py     (seq_py),
    .ctl_out(out_ctl),
    .vert_x (out_vert_x),
    .vert_y (out_vert_y)
  );

  assign out_valid        = out_ctl.valid;
  assign out_tex_u        = out_ctl.u;
  assign out_tex_v        = out_ctl.v;
  assign out_slot_out     = out_ctl.slot;
  assign out_corner_index = out_ctl.idx;
  assign out_last_corner  = out_ctl.last;

endmodule

### sv/rtqc_sincos.sv
// Quarter-wave sine/cosine lookup: address stage, registered table read, sign stage.
module rtqc_sincos #(
  parameter int SINE_TABLE_DEPTH   = rtqc_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SINE_FRACTION_BITS = rtqc_pkg::SINE_FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic [rtqc_pkg::ANGLE_W-1:0]        angle,
  output logic signed [SINE_FRACTION_BITS+1:0] sin_out,
  output logic signed [SINE_FRACTION_BITS+1:0] cos_out
);
  import rtqc_pkg::*;

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MW = 14 + IW;
  localparam int TW = SINE_FRACTION_BITS + 1;
  localparam int SW = SINE_FRACTION_BITS + 2;

  logic [TW-1:0] tbl [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tbl
    localparam longint unsigned XK = (64'(k) * PI_HALF_Q30) / SINE_TABLE_DEPTH;
    localparam logic [63:0] EK = sine_entry(XK, SINE_FRACTION_BITS);
    assign tbl[k] = EK[TW-1:0];
  end

  logic [ANGLE_W-1:0] angle_c;
  logic [MW-1:0]      prod_s, prod_c;
  logic [IW-1:0]      idx_s, idx_c, addr_s, addr_c;

  assign angle_c = angle + QUARTER_TURN;
  assign prod_s  = MW'(angle[13:0]) * MW'(SINE_TABLE_DEPTH);
  assign prod_c  = MW'(angle_c[13:0]) * MW'(SINE_TABLE_DEPTH);
  assign idx_s   = prod_s[MW-1:14];
  assign idx_c   = prod_c[MW-1:14];
  assign addr_s  = angle[14] ? IW'(SINE_TABLE_DEPTH) - idx_s : idx_s;
  assign addr_c  = angle_c[14] ? IW'(SINE_TABLE_DEPTH) - idx_c : idx_c;

  logic [TW-1:0]        ts_r, tc_r;
  logic                 neg_s_r, neg_c_r;
  logic signed [SW-1:0] sin_r, cos_r;

  always_ff @(posedge clk) begin
    ts_r    <= tbl[addr_s];
    tc_r    <= tbl[addr_c];
    neg_s_r <= angle[15];
    neg_c_r <= angle_c[15];
    sin_r   <= neg_s_r ? -$signed({1'b0, ts_r}) : $signed({1'b0, ts_r});
    cos_r   <= neg_c_r ? -$signed({1'b0, tc_r}) : $signed({1'b0, tc_r});
  end

  assign sin_out = sin_r;
  assign cos_out = cos_r;

endmodule

### sv/rtqc_corner_seq.sv
// Corner sequencer: holds one sprite and steps through its four corners, one per cycle.
module rtqc_corner_seq #(
  parameter int SINE_FRACTION_BITS = rtqc_pkg::SINE_FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic signed [SINE_FRACTION_BITS+1:0] sin_in,
  input  logic signed [SINE_FRACTION_BITS+1:0] cos_in,
  input  logic signed [rtqc_pkg::CW-1:0]       lx,
  input  logic signed [rtqc_pkg::CW-1:0]       rx,
  input  logic signed [rtqc_pkg::CW-1:0]       by,
  input  logic signed [rtqc_pkg::CW-1:0]       ty,
  input  logic signed [rtqc_pkg::POS_W-1:0]    px,
  input  logic signed [rtqc_pkg::POS_W-1:0]    py,
  input  logic [rtqc_pkg::SLOT_W-1:0]          slot,
  output rtqc_pkg::corner_ctl_t                ctl,
  output logic signed [rtqc_pkg::CW-1:0]       cx,
  output logic signed [rtqc_pkg::CW-1:0]       cy,
  output logic signed [SINE_FRACTION_BITS+1:0] sin_out,
  output logic signed [SINE_FRACTION_BITS+1:0] cos_out,
  output logic signed [rtqc_pkg::POS_W-1:0]    px_out,
  output logic signed [rtqc_pkg::POS_W-1:0]    py_out
);
  import rtqc_pkg::*;

  localparam int SW = SINE_FRACTION_BITS + 2;

  logic                 act_r;
  corner_t              k_r;
  logic signed [SW-1:0] sin_r, cos_r;
  logic signed [CW-1:0] lx_r, rx_r, by_r, ty_r;
  logic signed [POS_W-1:0] px_r, py_r;
  logic [SLOT_W-1:0]    slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      k_r   <= CORNER_LB;
    end else if (load) begin
      act_r <= 1'b1;
      k_r   <= CORNER_LB;
    end else if (act_r) begin
      if (k_r == CORNER_LT) begin
        act_r <= 1'b0;
      end
      k_r <= corner_t'(k_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sin_r  <= sin_in;
      cos_r  <= cos_in;
      lx_r   <= lx;
      rx_r   <= rx;
      by_r   <= by;
      ty_r   <= ty;
      px_r   <= px;
      py_r   <= py;
      slot_r <= slot;
    end
  end

  always_comb begin
    ctl.valid = act_r;
    ctl.idx   = k_r;
    ctl.u     = (k_r == CORNER_RB) || (k_r == CORNER_RT);
    ctl.v     = (k_r == CORNER_RT) || (k_r == CORNER_LT);
    ctl.last  = (k_r == CORNER_LT);
    ctl.slot  = slot_r;
  end

  assign cx      = ((k_r == CORNER_LB) || (k_r == CORNER_LT)) ? lx_r : rx_r;
  assign cy      = ((k_r == CORNER_LB) || (k_r == CORNER_RB)) ? by_r : ty_r;
  assign sin_out = sin_r;
  assign cos_out = cos_r;
  assign px_out  = px_r;
  assign py_out  = py_r;

endmodule

### sv/rtqc_corner_math.sv
// Corner arithmetic pipeline: rotate products, sum and round, translate and saturate.
module rtqc_corner_math #(
  parameter int SINE_FRACTION_BITS = rtqc_pkg::SINE_FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rtqc_pkg::corner_ctl_t                ctl,
  input  logic signed [rtqc_pkg::CW-1:0]       cx,
  input  logic signed [rtqc_pkg::CW-1:0]       cy,
  input  logic signed [SINE_FRACTION_BITS+1:0] sin_in,
  input  logic signed [SINE_FRACTION_BITS+1:0] cos_in,
  input  logic signed [rtqc_pkg::POS_W-1:0]    px,
  input  logic signed [rtqc_pkg::POS_W-1:0]    py,
  output rtqc_pkg::corner_ctl_t                ctl_out,
  output logic signed [rtqc_pkg::POS_W-1:0]    vert_x,
  output logic signed [rtqc_pkg::POS_W-1:0]    vert_y
);
  import rtqc_pkg::*;

  localparam int SW   = SINE_FRACTION_BITS + 2;
  localparam int PW   = SW + CW;
  localparam int AW   = PW + 1;
  localparam int RW   = AW - SINE_FRACTION_BITS - 1;
  localparam int SUMW = RW + 1;
  localparam logic signed [AW-1:0]   HALF  = AW'(1) << SINE_FRACTION_BITS;
  localparam logic signed [SUMW-1:0] S_MAX = SUMW'(POS_MAX);
  localparam logic signed [SUMW-1:0] S_MIN = SUMW'(POS_MIN);

  corner_ctl_t             ctl_m_r, ctl_r_r, ctl_o_r;
  logic signed [PW-1:0]    pcx_r, psy_r, pcy_r, psx_r;
  logic signed [POS_W-1:0] px_m_r, py_m_r, px_r_r, py_r_r;
  logic signed [RW-1:0]    rx_r, ry_r;
  logic signed [POS_W-1:0] vx_r, vy_r;

  logic signed [AW-1:0]   acc_x, acc_y, sh_x, sh_y;
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic signed [POS_W-1:0] vx_nxt, vy_nxt;

  assign acc_x = AW'(pcx_r) + AW'(psy_r);
  assign acc_y = AW'(pcy_r) - AW'(psx_r);
  assign sh_x  = (acc_x + HALF) >>> (SINE_FRACTION_BITS + 1);
  assign sh_y  = (acc_y + HALF) >>> (SINE_FRACTION_BITS + 1);

  assign sum_x = SUMW'(rx_r) + SUMW'(px_r_r);
  assign sum_y = SUMW'(ry_r) + SUMW'(py_r_r);

  always_comb begin
    priority if (sum_x > S_MAX) begin
      vx_nxt = POS_MAX;
    end else if (sum_x < S_MIN) begin
      vx_nxt = POS_MIN;
    end else begin
      vx_nxt = sum_x[POS_W-1:0];
    end
    priority if (sum_y > S_MAX) begin
      vy_nxt = POS_MAX;
    end else if (sum_y < S_MIN) begin
      vy_nxt = POS_MIN;
    end else begin
      vy_nxt = sum_y[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r.valid <= 1'b0;
      ctl_r_r.valid <= 1'b0;
      ctl_o_r.valid <= 1'b0;
    end else begin
      ctl_m_r.valid <= ctl.valid;
      ctl_r_r.valid <= ctl_m_r.valid;
      ctl_o_r.valid <= ctl_r_r.valid;
    end
    ctl_m_r.idx  <= ctl.idx;
    ctl_m_r.u    <= ctl.u;
    ctl_m_r.v    <= ctl.v;
    ctl_m_r.last <= ctl.last;
    ctl_m_r.slot <= ctl.slot;
    ctl_r_r.idx  <= ctl_m_r.idx;
    ctl_r_r.u    <= ctl_m_r.u;
    ctl_r_r.v    <= ctl_m_r.v;
    ctl_r_r.last <= ctl_m_r.last;
    ctl_r_r.slot <= ctl_m_r.slot;
    ctl_o_r.idx  <= ctl_r_r.idx;
    ctl_o_r.u    <= ctl_r_r.u;
    ctl_o_r.v    <= ctl_r_r.v;
    ctl_o_r.last <= ctl_r_r.last;
    ctl_o_r.slot <= ctl_r_r.slot;
    pcx_r  <= cos_in * cx;
    psy_r  <= sin_in * cy;
    pcy_r  <= cos_in * cy;
    psx_r  <= sin_in * cx;
    px_m_r <= px;
    py_m_r <= py;
    rx_r   <= sh_x[RW-1:0];
    ry_r   <= sh_y[RW-1:0];
    px_r_r <= px_m_r;
    py_r_r <= py_m_r;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
  end

  assign ctl_out = ctl_o_r;
  assign vert_x  = vx_r;
  assign vert_y  = vy_r;

endmodule

### sv/rtqc_checker.sv
// Port-level checker for the rotated sprite corner generator, bound to the top level.
module rtqc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic                              out_tex_u,
  input logic                              out_tex_v,
  input logic [rtqc_pkg::SLOT_W-1:0]       out_slot_out,
  input logic [1:0]                        out_corner_index,
  input logic                              out_last_corner
);
  import rtqc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepting an item");

  a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner_index != CORNER_LT) |=>
      out_valid && (out_corner_index == $past(out_corner_index) + 2'd1))
    else $error("corners of an item not on consecutive cycles");

  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_corner_index != CORNER_LT) |=> out_slot_out == $past(out_slot_out))
    else $error("texture slot changed within an item");

  a_uv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_corner == (out_corner_index == CORNER_LT)) &&
      (out_tex_u == ((out_corner_index == CORNER_RB) || (out_corner_index == CORNER_RT))) &&
      (out_tex_v == ((out_corner_index == CORNER_RT) || (out_corner_index == CORNER_LT))))
    else $error("uv or last flag does not match corner index");

endmodule

bind rotated_textured_quad_corners rtqc_checker u_rtqc_checker (.*);

### tb/sv/rotated_textured_quad_corners_tb.sv
// Self-checking testbench for the rotated sprite corner generator: directed table, then random sprites.
module rotated_textured_quad_corners_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtqc_pkg::*;

  localparam int DEPTH        = SINE_TABLE_DEPTH_DEF;
  localparam int FRAC         = SINE_FRACTION_BITS_DEF;
  localparam int RANDOM_ITEMS = 100;
  localparam int CYCLE_LIMIT  = 40000;
  localparam int N_DIRECTED   = 22;
  localparam int MAX_PRINTS   = 40;

  typedef logic signed [POS_W-1:0] coord_t;

  typedef struct packed {
    coord_t              pos_x;
    coord_t              pos_y;
    logic [SIZE_W-1:0]   size_w;
    logic [SIZE_W-1:0]   size_h;
    logic [ANGLE_W-1:0]  angle;
    logic                centered;
    logic [SLOT_W-1:0]   tex_slot;
  } sprite_t;

  typedef struct packed {
    coord_t            x;
    coord_t            y;
    logic              u;
    logic              v;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        idx;
    logic              last;
  } vertex_t;

  typedef struct packed {
    sprite_t                s;
    logic                   typed;
    logic [0:3][POS_W-1:0]  ex;
    logic [0:3][POS_W-1:0]  ey;
  } row_t;

  localparam logic [SIZE_W-1:0] SZ_MAX = 23'h7FFFFF;

  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{'{0, 0, 0, 0, 16'h0000, 0, 0}, 1, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{4096, -4096, 256, 512, 16'h0000, 0, 1}, 1,
      '{4096, 4352, 4352, 4096}, '{-4096, -4096, -3584, -3584}},
    '{'{0, 0, 512, 256, 16'h0000, 1, 2}, 1, '{-256, 256, 256, -256}, '{-128, -128, 128, 128}},
    // half-unit corners round up on ties
    '{'{0, 0, 1, 1, 16'h0000, 1, 4}, 1, '{0, 1, 1, 0}, '{0, 0, 1, 1}},
    '{'{POS_MAX, POS_MAX, SZ_MAX, SZ_MAX, 16'h0000, 0, 31}, 1,
      '{POS_MAX, POS_MAX, POS_MAX, POS_MAX}, '{POS_MAX, POS_MAX, POS_MAX, POS_MAX}},
    '{'{POS_MIN, POS_MIN, SZ_MAX, SZ_MAX, 16'h8000, 0, 0}, 1,
      '{POS_MIN, POS_MIN, POS_MIN, POS_MIN}, '{POS_MIN, POS_MIN, POS_MIN, POS_MIN}},
    '{'{0, 0, 256, 512, 16'h4000, 0, 3}, 1, '{0, 0, 512, 512}, '{0, -256, -256, 0}},
    '{'{0, 0, 256, 256, 16'hC000, 0, 5}, 0, '0, '0},
    '{'{-4096, 8192, 1000, 700, 16'h2000, 1, 6}, 0, '0, '0},
    '{'{1234, -5678, 3000, 100, 16'h6000, 0, 7}, 0, '0, '0},
    '{'{-1, -1, 255, 511, 16'hA000, 1, 8}, 0, '0, '0},
    '{'{100000, -100000, 50000, 20000, 16'hE000, 0, 9}, 0, '0, '0},
    '{'{0, 0, 4096, 4096, 16'h0001, 1, 10}, 0, '0, '0},
    '{'{0, 0, 4096, 4096, 16'h3FFF, 0, 11}, 0, '0, '0},
    '{'{0, 0, 4096, 4096, 16'h4001, 1, 12}, 0, '0, '0},
    '{'{0, 0, 4096, 4096, 16'hFFFF, 0, 13}, 0, '0, '0},
    '{'{0, 0, 4096, 4096, 16'h7FFF, 1, 14}, 0, '0, '0},
    '{'{0, 0, SZ_MAX, SZ_MAX, 16'h2000, 1, 16}, 0, '0, '0},
    '{'{POS_MAX, POS_MIN, SZ_MAX, 0, 16'h1234, 0, 30}, 0, '0, '0},
    '{'{POS_MIN, POS_MAX, 0, SZ_MAX, 16'hBEEF, 1, 31}, 0, '0, '0},
    '{'{-8388000, 8388000, 65536, 65536, 16'h9000, 0, 17}, 0, '0, '0},
    '{'{24'h555555, 24'hAAAAAA, 23'h2AAAAA, 23'h555555, 16'hA5A5, 1, 21}, 0, '0, '0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  coord_t               in_pos_x;
  coord_t               in_pos_y;
  logic [SIZE_W-1:0]    in_size_w;
  logic [SIZE_W-1:0]    in_size_h;
  logic [ANGLE_W-1:0]   in_angle;
  logic                 in_centered;
  logic [SLOT_W-1:0]    in_tex_slot;
  logic                 out_valid;
  coord_t               out_vert_x;
  coord_t               out_vert_y;
  logic                 out_tex_u;
  logic                 out_tex_v;
  logic [SLOT_W-1:0]    out_slot_out;
  logic [1:0]           out_corner_index;
  logic                 out_last_corner;

  longint  sine_lut [0:DEPTH];
  vertex_t expected_corners [$];
  int      errors;
  int      cycle_count;
  int      sprites_sent;
  int      corners_seen;
  int      rail_hits;
  bit      idle_on;
  logic [3:0] quadrants_seen;

  rotated_textured_quad_corners DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_size_w        (in_size_w),
    .in_size_h        (in_size_h),
    .in_angle         (in_angle),
    .in_centered      (in_centered),
    .in_tex_slot      (in_tex_slot),
    .out_valid        (out_valid),
    .out_vert_x       (out_vert_x),
    .out_vert_y       (out_vert_y),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_slot_out     (out_slot_out),
    .out_corner_index (out_corner_index),
    .out_last_corner  (out_last_corner)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic longint unsigned quarter_sine(longint unsigned x);
    longint unsigned term;
    longint          acc;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(ONE_Q30)) begin
      acc = longint'(ONE_Q30);
    end
    return (unsigned'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
  endfunction

  function automatic longint lut_sine(logic [ANGLE_W-1:0] a);
    int i;
    i = (int'(a[13:0]) * DEPTH) >>> 14;
    if (i > DEPTH) begin
      i = DEPTH;
    end
    case (a[15:14])
      2'd0: return sine_lut[i];
      2'd1: return sine_lut[DEPTH - i];
      2'd2: return -sine_lut[i];
      default: return -sine_lut[DEPTH - i];
    endcase
  endfunction

  function automatic coord_t round_to_q8(longint acc, longint pos);
    longint r;
    r = ((acc + (longint'(1) <<< FRAC)) >>> (FRAC + 1)) + pos;
    if (r > longint'(POS_MAX)) begin
      r = longint'(POS_MAX);
    end
    if (r < longint'(POS_MIN)) begin
      r = longint'(POS_MIN);
    end
    return r[POS_W-1:0];
  endfunction

  function automatic void quad_corners(input sprite_t s, output vertex_t quad [4]);
    longint w, h, px, py, sn, cs, lx, rx, by, ty, cx, cy;
    logic [ANGLE_W-1:0] cos_angle;
    corner_t c;
    w  = longint'(s.size_w);
    h  = longint'(s.size_h);
    px = longint'($signed(s.pos_x));
    py = longint'($signed(s.pos_y));
    if (s.centered) begin
      lx = -w; rx = w; by = -h; ty = h;
    end else begin
      lx = 0; rx = 2 * w; by = 0; ty = 2 * h;
    end
    cos_angle = s.angle + QUARTER_TURN;
    sn = lut_sine(s.angle);
    cs = lut_sine(cos_angle);
    for (int k = 0; k < 4; k++) begin
      c  = corner_t'(k);
      cx = (c == CORNER_LB || c == CORNER_LT) ? lx : rx;
      cy = (c == CORNER_LB || c == CORNER_RB) ? by : ty;
      quad[k].x    = round_to_q8(cs * cx + sn * cy, px);
      quad[k].y    = round_to_q8(cs * cy - sn * cx, py);
      quad[k].u    = (c == CORNER_RB || c == CORNER_RT);
      quad[k].v    = (c == CORNER_RT || c == CORNER_LT);
      quad[k].slot = s.tex_slot;
      quad[k].idx  = c;
      quad[k].last = (c == CORNER_LT);
    end
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t     s;
    int unsigned pick;
    logic [13:0] phase;
    pick       = $urandom_range(99);
    s.pos_x    = 24'($urandom);
    s.pos_y    = 24'($urandom);
    s.size_w   = 23'($urandom);
    s.size_h   = 23'($urandom);
    s.angle    = 16'($urandom);
    s.centered = 1'($urandom);
    s.tex_slot = 5'($urandom);
    if (pick < 60) begin
      s.pos_x  = 24'($urandom_range(2097151)) - 24'd1048576;
      s.pos_y  = 24'($urandom_range(2097151)) - 24'd1048576;
      s.size_w = 23'($urandom_range(65535));
      s.size_h = 23'($urandom_range(65535));
    end else if (pick < 75) begin
      s.pos_x  = $urandom_range(1) ? POS_MAX - 24'($urandom_range(65535))
                                   : POS_MIN + 24'($urandom_range(65535));
      s.pos_y  = $urandom_range(1) ? POS_MAX - 24'($urandom_range(65535))
                                   : POS_MIN + 24'($urandom_range(65535));
      s.size_w = 23'($urandom_range(1048575));
      s.size_h = 23'($urandom_range(1048575));
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0: phase = 14'h0000;
        1: phase = 14'h0001;
        2: phase = 14'h3FFF;
        default: phase = 14'h2000;
      endcase
      s.angle  = {2'($urandom_range(3)), phase};
      s.size_w = 23'($urandom_range(1023));
      s.size_h = 23'($urandom_range(1023));
    end
    return s;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d, %s: got %0d expected %0d",
               cycle_count, field, got, want);
    end
  endtask

  task automatic send_sprite(input sprite_t s, input logic typed,
                             input logic [0:3][POS_W-1:0] ex,
                             input logic [0:3][POS_W-1:0] ey);
    vertex_t quad [4];
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 13) begin
      start = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_pos_x    = s.pos_x;
    in_pos_y    = s.pos_y;
    in_size_w   = s.size_w;
    in_size_h   = s.size_h;
    in_angle    = s.angle;
    in_centered = s.centered;
    in_tex_slot = s.tex_slot;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    quad_corners(s, quad);
    for (int k = 0; k < 4; k++) begin
      if (typed) begin
        quad[k].x = ex[k];
        quad[k].y = ey[k];
      end
      expected_corners.push_back(quad[k]);
    end
    quadrants_seen[s.angle[15:14]] = 1'b1;
    sprites_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d corners outstanding",
               cycle_count, expected_corners.size());
      $display("rotated_textured_quad_corners regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid) begin
      corners_seen++;
      if (out_vert_x == POS_MAX || out_vert_x == POS_MIN ||
          out_vert_y == POS_MAX || out_vert_y == POS_MIN) begin
        rail_hits++;
      end
      if (expected_corners.size() == 0) begin
        report_mismatch("unexpected corner, index", out_corner_index, 0);
      end else begin
        want = expected_corners.pop_front();
        if (out_vert_x !== want.x) begin
          report_mismatch("vert_x", $signed(out_vert_x), $signed(want.x));
        end
        if (out_vert_y !== want.y) begin
          report_mismatch("vert_y", $signed(out_vert_y), $signed(want.y));
        end
        if (out_tex_u !== want.u) begin
          report_mismatch("tex_u", out_tex_u, want.u);
        end
        if (out_tex_v !== want.v) begin
          report_mismatch("tex_v", out_tex_v, want.v);
        end
        if (out_slot_out !== want.slot) begin
          report_mismatch("slot_out", out_slot_out, want.slot);
        end
        if (out_corner_index !== want.idx) begin
          report_mismatch("corner_index", out_corner_index, want.idx);
        end
        if (out_last_corner !== want.last) begin
          report_mismatch("last_corner", out_last_corner, want.last);
        end
      end
    end
  end

  initial begin
    errors         = 0;
    cycle_count    = 0;
    sprites_sent   = 0;
    corners_seen   = 0;
    rail_hits      = 0;
    quadrants_seen = '0;
    idle_on        = 1'b1;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_size_w      = '0;
    in_size_h      = '0;
    in_angle       = '0;
    in_centered    = 1'b0;
    in_tex_slot    = '0;
    for (int k = 0; k <= DEPTH; k++) begin
      sine_lut[k] = longint'(quarter_sine((PI_HALF_Q30 * k) / DEPTH));
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_sprite(DIRECTED[r].s, DIRECTED[r].typed, DIRECTED[r].ex, DIRECTED[r].ey);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = !(i >= 40 && i < 80);
      send_sprite(random_sprite(), 1'b0, '0, '0);
    end
    @(negedge clk);
    start = 1'b0;

    while (expected_corners.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("drove %0d sprites (%0d from the table), checked %0d corners",
             sprites_sent, N_DIRECTED, corners_seen);
    $display("angle quadrants hit %b, %0d corners on a saturation rail",
             quadrants_seen, rail_hits);
    if (errors == 0) begin
      $display("rotated_textured_quad_corners regression: pass");
    end else begin
      $display("rotated_textured_quad_corners regression: fail");
    end
    $finish;
  end

endmodule
